// ===== hdl/ksg_pkg.sv =====
// ----------------------------------------------------------------------------
// ksg_pkg: shared types and constants of the keyed sidetone generator
// Fixed-point coefficients (Q30), command and register codes, tone states,
// the ramp-length rule and the truncating Q30 product scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package ksg_pkg;

   // Fixed numeric settings of the tone path
   localparam int SAMPLE_RATE    = 48000;
   localparam int MAX_RAMP       = 4095;
   localparam int MAX_RAMP_ODD   = (MAX_RAMP % 2 == 0) ? MAX_RAMP - 1 : MAX_RAMP;
   localparam int COS_TABLE_BITS = 10;

   // Shared multiplier operand and product widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // Shared divider widths
   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 32;

   typedef logic signed [MUL_W-1:0]  q30_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam q30_type  Q30_ONE    = 33'sd1073741824;
   localparam prod_type TRUNC_BIAS = 66'sd1073741823;

   // Odd polynomial of the quarter-wave sine
   localparam q30_type SIN_C0 = 33'sd1686629713;
   localparam q30_type SIN_C1 = -33'sd693598669;
   localparam q30_type SIN_C2 = 33'sd85569306;
   localparam q30_type SIN_C3 = -33'sd5026996;
   localparam q30_type SIN_C4 = 33'sd172272;

   // Blackman-Harris window coefficients
   localparam q30_type BH_A0 = 33'sd385204879;
   localparam q30_type BH_A1 = 33'sd524297395;
   localparam q30_type BH_A2 = 33'sd151698245;
   localparam q30_type BH_A3 = 33'sd12541305;

   // Key command codes
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_ON   = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_VOLUME  = 2'd0;
   localparam logic [1:0] REG_ATTACK  = 2'd1;
   localparam logic [1:0] REG_RELEASE = 2'd2;

   localparam logic [4:0] MAX_GAIN = 5'd20;

   typedef enum logic [1:0] {
      TONE_OFF  = 2'd0,
      TONE_RISE = 2'd1,
      TONE_ON   = 2'd2,
      TONE_FALL = 2'd3
   } tone_type;

   // Register contents as seen by the sequencer
   typedef struct packed {
      logic [4:0]  volume;
      logic [11:0] attack_len;
      logic [11:0] release_len;
   } ksg_cfg_type;

   // Write strobes that restart a running ramp
   typedef struct packed {
      logic attack_wr;
      logic release_wr;
   } ksg_cfg_wr_type;

   // Finished result handed to the output register
   typedef struct packed {
      logic        load;
      logic [15:0] sample;
      logic [1:0]  phase;
   } ksg_result_type;

   // Ramp length: zero acts as one, even values go up by one, limit kept odd
   function automatic logic [11:0] ramp_length(input logic [11:0] r);
      logic [11:0] n;
      n = r;
      if (n == 12'd0) begin
         n = 12'd1;
      end
      if (!n[0]) begin
         n = n + 12'd1;
      end
      if (32'(n) > MAX_RAMP) begin
         n = 12'(MAX_RAMP_ODD);
      end
      return n;
   endfunction

   // Q30 product scaled back, truncated toward zero
   function automatic q30_type mulq(input prod_type p);
      prod_type adj;
      adj = p[PROD_W-1] ? (p + TRUNC_BIAS) : p;
      return q30_type'(adj >>> 30);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ksg_mul.sv =====
// ----------------------------------------------------------------------------
// ksg_mul: shared signed multiplier
// Registered signed product of two Q30-range operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ksg_mul (
   input  wire logic             clock,
   input  wire ksg_pkg::q30_type op_a,
   input  wire ksg_pkg::q30_type op_b,
   output ksg_pkg::prod_type     prod
);
   import ksg_pkg::*;

   prod_type prod_ff;

   // Register the full product
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hdl/ksg_div.sv =====
// ----------------------------------------------------------------------------
// ksg_div: shared restoring divider
// Unsigned division, one quotient bit per cycle over the full dividend width.
// ----------------------------------------------------------------------------
`default_nettype none

module ksg_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [ksg_pkg::DIVIDEND_W-1:0]   dividend,
   input  wire logic [ksg_pkg::DIVISOR_W-1:0]    divisor,
   output logic                                  done,
   output logic [ksg_pkg::DIVIDEND_W-1:0]        quotient
);
   import ksg_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;
   logic                  fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      fits    = !diff[DIVISOR_W+1];
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W:0] : shifted;
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/ksg_seq.sv =====
// ----------------------------------------------------------------------------
// ksg_seq: tick sequencer and datapath
// Keeps the tone state and walks each tick through key handling, envelope,
// oscillator cosine and output scaling on the shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ksg_seq #(
   parameter int PHASE_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [1:0]                       cmd,
   input  wire logic [15:0]                      freq_hz,
   input  wire ksg_pkg::ksg_cfg_type             cfg,
   input  wire ksg_pkg::ksg_cfg_wr_type          cfg_wr,
   input  wire logic                             out_free,
   output logic                                  idle,
   output ksg_pkg::ksg_result_type               result,
   output ksg_pkg::q30_type                      mul_a,
   output ksg_pkg::q30_type                      mul_b,
   input  wire ksg_pkg::prod_type                mul_prod,
   output logic                                  div_start,
   output logic [ksg_pkg::DIVIDEND_W-1:0]        div_dividend,
   output logic [ksg_pkg::DIVISOR_W-1:0]         div_divisor,
   input  wire logic                             div_done,
   input  wire logic [ksg_pkg::DIVIDEND_W-1:0]   div_quotient
);
   import ksg_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE   = 14'h0001,
      S_CHECK  = 14'h0002,
      S_INC    = 14'h0004,
      S_ENV    = 14'h0008,
      S_WDIV   = 14'h0010,
      S_ENVSET = 14'h0020,
      S_PHASE  = 14'h0040,
      S_COS    = 14'h0080,
      S_WACC   = 14'h0100,
      S_OSC    = 14'h0200,
      S_GAIN   = 14'h0400,
      S_SDIV   = 14'h0800,
      S_DONE   = 14'h1000,
      S_SSTART = 14'h2000
   } seq_state_type;

   localparam int TURN_PAD = 32 - COS_TABLE_BITS;

   seq_state_type         state_ff, state_in;
   logic                  wait_ff, wait_in;
   logic [2:0]            step_ff, step_in;
   logic [1:0]            harm_ff, harm_in;
   tone_type              tone_ff, tone_in;
   logic [11:0]           ramp_ff, ramp_in;
   logic [15:0]           freq_ff, freq_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] inc_ff, inc_in;
   logic                  stale_ff, stale_in;

   logic [11:0]           n_ff, n_in;
   logic [31:0]           t_ff, t_in;
   logic [31:0]           ang_ff, ang_in;
   q30_type               x_ff, x_in;
   q30_type               x2_ff, x2_in;
   logic                  neg_ff, neg_in;
   q30_type               win_ff, win_in;
   q30_type               env_ff, env_in;
   logic                  sneg_ff, sneg_in;
   logic [15:0]           sample_ff, sample_in;
   q30_type               op_a_ff, op_a_in;
   q30_type               op_b_ff, op_b_in;

   q30_type               r_q;
   logic [11:0]           n_cur;
   logic [31:0]           cos_s;
   logic [30:0]           cos_f;
   q30_type               cos_v;
   q30_type               cos_val;
   q30_type               w_clamp;
   logic [PHASE_BITS-1:0] phase_sum;
   prod_type              m_mag;
   logic [16:0]           q17;
   logic [17:0]           q_neg;
   q30_type               gain_q;
   q30_type               bh_coef;
   logic [11:0]           ramp_next;

   // Shared helper values
   always_comb begin
      r_q     = mulq(mul_prod);
      n_cur   = (tone_ff == TONE_RISE) ? ramp_length(cfg.attack_len)
                                       : ramp_length(cfg.release_len);
      // Quarter-wave folding of the cosine angle
      cos_s   = ang_ff + 32'h4000_0000;
      cos_f   = cos_s[1+29] ? 31'h4000_0000 - {1'b0, cos_s[29:0]} : {1'b0, cos_s[29:0]};
      cos_f   = cos_s[30] ? 31'h4000_0000 - {1'b0, cos_s[29:0]} : {1'b0, cos_s[29:0]};
      cos_v   = r_q;
      if (r_q < 0) begin
         cos_v = '0;
      end else if (r_q > Q30_ONE) begin
         cos_v = Q30_ONE;
      end
      cos_val = neg_ff ? -cos_v : cos_v;
      w_clamp = win_ff;
      if (win_ff < 0) begin
         w_clamp = '0;
      end else if (win_ff > Q30_ONE) begin
         w_clamp = Q30_ONE;
      end
      phase_sum = phase_ff + inc_ff;
      m_mag     = mul_prod[PROD_W-1] ? -mul_prod : mul_prod;
      q17       = div_quotient[16:0];
      q_neg     = -{1'b0, q17};
      gain_q    = (cfg.volume > MAX_GAIN) ? q30_type'(MAX_GAIN)
                                          : q30_type'(cfg.volume);
      ramp_next = (ramp_ff < n_ff) ? ramp_ff + 12'd1 : ramp_ff;
      case (harm_ff)
         2'd1:    bh_coef = BH_A1;
         2'd2:    bh_coef = BH_A2;
         default: bh_coef = BH_A3;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      wait_in      = 1'b0;
      step_in      = step_ff;
      harm_in      = harm_ff;
      tone_in      = tone_ff;
      ramp_in      = ramp_ff;
      freq_in      = freq_ff;
      phase_in     = phase_ff;
      inc_in       = inc_ff;
      stale_in     = stale_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      ang_in       = ang_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      neg_in       = neg_ff;
      win_in       = win_ff;
      env_in       = env_ff;
      sneg_in      = sneg_ff;
      sample_in    = sample_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      result.load  = 1'b0;

      // Restart a running ramp when its length is rewritten
      if (cfg_wr.attack_wr && tone_ff == TONE_RISE) begin
         ramp_in = '0;
      end
      if (cfg_wr.release_wr && tone_ff == TONE_FALL) begin
         ramp_in = '0;
      end

      if (!wait_ff) begin
         case (state_ff)
            S_IDLE: begin
               // Apply the key command of this tick
               if (start) begin
                  if (cmd == CMD_ON) begin
                     if (freq_hz != freq_ff) begin
                        freq_in  = freq_hz;
                        phase_in = '0;
                        stale_in = 1'b1;
                     end
                     tone_in = TONE_RISE;
                     ramp_in = '0;
                  end else if (cmd == CMD_OFF && tone_ff != TONE_OFF) begin
                     tone_in = TONE_FALL;
                     ramp_in = '0;
                  end
                  state_in = S_CHECK;
               end
            end
            S_CHECK: begin
               if (tone_ff == TONE_OFF) begin
                  sample_in = '0;
                  state_in  = S_DONE;
               end else if (stale_ff) begin
                  div_start    = 1'b1;
                  div_dividend = DIVIDEND_W'({freq_ff, {PHASE_BITS{1'b0}}});
                  div_divisor  = DIVISOR_W'(SAMPLE_RATE);
                  state_in     = S_INC;
               end else begin
                  state_in = S_ENV;
               end
            end
            S_INC: begin
               // Oscillator increment for the new frequency
               if (div_done) begin
                  inc_in   = div_quotient[PHASE_BITS-1:0];
                  stale_in = 1'b0;
                  state_in = S_ENV;
               end
            end
            S_ENV: begin
               n_in = n_cur;
               if (tone_ff == TONE_ON) begin
                  env_in   = Q30_ONE;
                  state_in = S_PHASE;
               end else if (n_cur == 12'd1 || ramp_ff >= n_cur) begin
                  win_in   = Q30_ONE;
                  state_in = S_ENVSET;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = DIVIDEND_W'({ramp_ff, 31'd0});
                  div_divisor  = DIVISOR_W'(n_cur - 12'd1);
                  state_in     = S_WDIV;
               end
            end
            S_WDIV: begin
               // Window angle in turn units, then the first harmonic
               if (div_done) begin
                  t_in     = div_quotient[31:0];
                  ang_in   = div_quotient[31:0];
                  harm_in  = 2'd1;
                  win_in   = BH_A0;
                  step_in  = '0;
                  state_in = S_COS;
               end
            end
            S_COS: begin
               // Quarter-wave polynomial, one product per step
               case (step_ff)
                  3'd0: begin
                     x_in    = q30_type'(cos_f);
                     neg_in  = cos_s[31];
                     op_a_in = q30_type'(cos_f);
                     op_b_in = q30_type'(cos_f);
                  end
                  3'd1: begin
                     x2_in   = r_q;
                     op_a_in = SIN_C4;
                     op_b_in = r_q;
                  end
                  3'd2: begin
                     op_a_in = SIN_C3 + r_q;
                     op_b_in = x2_ff;
                  end
                  3'd3: begin
                     op_a_in = SIN_C2 + r_q;
                     op_b_in = x2_ff;
                  end
                  3'd4: begin
                     op_a_in = SIN_C1 + r_q;
                     op_b_in = x2_ff;
                  end
                  3'd5: begin
                     op_a_in = SIN_C0 + r_q;
                     op_b_in = x_ff;
                  end
                  default: begin
                     if (harm_ff == 2'd0) begin
                        op_a_in  = env_ff;
                        op_b_in  = cos_val;
                        state_in = S_OSC;
                     end else begin
                        op_a_in  = bh_coef;
                        op_b_in  = cos_val;
                        state_in = S_WACC;
                     end
                  end
               endcase
               step_in = step_ff + 3'd1;
               wait_in = 1'b1;
            end
            S_WACC: begin
               // Accumulate one window term, move to the next harmonic
               win_in  = (harm_ff == 2'd2) ? win_ff + r_q : win_ff - r_q;
               step_in = '0;
               if (harm_ff == 2'd3) begin
                  state_in = S_ENVSET;
               end else begin
                  harm_in  = harm_ff + 2'd1;
                  ang_in   = (harm_ff == 2'd1) ? {t_ff[30:0], 1'b0}
                                               : t_ff + {t_ff[30:0], 1'b0};
                  state_in = S_COS;
               end
            end
            S_ENVSET: begin
               // Envelope from the window, advance the ramp
               env_in  = (tone_ff == TONE_RISE) ? w_clamp : Q30_ONE - w_clamp;
               ramp_in = ramp_next;
               if (ramp_next >= n_ff) begin
                  tone_in = (tone_ff == TONE_RISE) ? TONE_ON : TONE_OFF;
               end
               state_in = S_PHASE;
            end
            S_PHASE: begin
               // Advance the oscillator and take its top bits as the angle
               phase_in = phase_sum;
               ang_in   = {phase_sum[PHASE_BITS-1 -: COS_TABLE_BITS], {TURN_PAD{1'b0}}};
               harm_in  = 2'd0;
               step_in  = '0;
               state_in = S_COS;
            end
            S_OSC: begin
               op_a_in  = r_q;
               op_b_in  = gain_q;
               wait_in  = 1'b1;
               state_in = S_GAIN;
            end
            S_GAIN: begin
               // Scale by gain / 20 / 2^15 as |m| / 2^17 / 5
               sneg_in  = mul_prod[PROD_W-1];
               x_in     = q30_type'(m_mag[PROD_W-1:17]);
               state_in = S_SSTART;
            end
            S_SSTART: begin
               div_start    = 1'b1;
               div_dividend = DIVIDEND_W'(x_ff);
               div_divisor  = DIVISOR_W'(5);
               state_in     = S_SDIV;
            end
            S_SDIV: begin
               // Restore the sign and saturate
               if (div_done) begin
                  if (sneg_ff) begin
                     sample_in = q_neg[15:0];
                  end else if (q17 > 17'd32767) begin
                     sample_in = 16'h7FFF;
                  end else begin
                     sample_in = q17[15:0];
                  end
                  state_in = S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  result.load = 1'b1;
                  state_in    = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   // Control and tone state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= 1'b0;
         step_ff  <= '0;
         harm_ff  <= '0;
         tone_ff  <= TONE_OFF;
         ramp_ff  <= '0;
         freq_ff  <= '0;
         phase_ff <= '0;
         inc_ff   <= '0;
         stale_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         step_ff  <= step_in;
         harm_ff  <= harm_in;
         tone_ff  <= tone_in;
         ramp_ff  <= ramp_in;
         freq_ff  <= freq_in;
         phase_ff <= phase_in;
         inc_ff   <= inc_in;
         stale_ff <= stale_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      t_ff      <= t_in;
      ang_ff    <= ang_in;
      x_ff      <= x_in;
      x2_ff     <= x2_in;
      neg_ff    <= neg_in;
      win_ff    <= win_in;
      env_ff    <= env_in;
      sneg_ff   <= sneg_in;
      sample_ff <= sample_in;
      op_a_ff   <= op_a_in;
      op_b_ff   <= op_b_in;
   end

   assign idle          = (state_ff == S_IDLE);
   assign result.sample = sample_ff;
   assign result.phase  = tone_ff;
   assign mul_a         = op_a_ff;
   assign mul_b         = op_b_ff;

endmodule

`default_nettype wire

// ===== hdl/keyed_sidetone_generator.sv =====
// ----------------------------------------------------------------------------
// keyed_sidetone_generator: keyed sidetone with Blackman-Harris key ramps
// Top level: stream ports, register file, output register.
// ----------------------------------------------------------------------------
// Each accepted request is one audio sample tick carrying a key command
// (none, tone on with a frequency in hertz, tone off) and gives exactly one
// response: a signed Q1.15 sample and the tone state after the tick. The
// rise and fall envelopes follow half a Blackman-Harris window over the
// attack and release lengths; the oscillator phase restarts only when a new
// frequency arrives. One tick is worked through by a sequencer over a shared
// 33x33 multiplier and a shared 64-step restoring divider: an off tick skips
// the arithmetic, a steady tone spends most of its time in the output scaling
// divide, a ramp tick adds the window angle divide and three window cosines,
// and a new frequency adds the increment divide. A new request is taken as
// soon as the previous response sits in the output register. Registers are
// written through the csr channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_sidetone_generator #(
   parameter int PHASE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] freq_hz
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // Response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] sample_out
   output logic [1:0]       rsp_tuser,   // [1:0] tone_phase
   // Register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);
   import ksg_pkg::*;

   logic [4:0]     volume_ff, volume_in;
   logic [11:0]    attack_ff, attack_in;
   logic [11:0]    release_ff, release_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]     rsp_user_ff, rsp_user_in;

   ksg_cfg_type    cfg;
   ksg_cfg_wr_type cfg_wr;
   ksg_result_type result;
   logic           csr_write;
   logic           seq_idle;
   logic           out_free;
   q30_type        mul_a, mul_b;
   prod_type       mul_prod;
   logic           div_start, div_done;
   logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
   logic [DIVISOR_W-1:0]  div_divisor;

   // Register file
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      volume_in         = volume_ff;
      attack_in         = attack_ff;
      release_in        = release_ff;
      cfg_wr.attack_wr  = 1'b0;
      cfg_wr.release_wr = 1'b0;
      if (csr_write) begin
         case (csr_index)
            REG_VOLUME: begin
               volume_in = csr_data[4:0];
            end
            REG_ATTACK: begin
               attack_in        = csr_data;
               cfg_wr.attack_wr = 1'b1;
            end
            REG_RELEASE: begin
               release_in        = csr_data;
               cfg_wr.release_wr = 1'b1;
            end
            default: begin
               volume_in = volume_ff;
            end
         endcase
      end
   end

   assign cfg.volume      = volume_ff;
   assign cfg.attack_len  = attack_ff;
   assign cfg.release_len = release_ff;

   // Output register: hold a finished transfer until it is taken
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (result.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.sample;
         rsp_user_in  = result.phase;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff    <= MAX_GAIN;
         attack_ff    <= 12'd241;
         release_ff   <= 12'd241;
         rsp_valid_ff <= 1'b0;
      end else begin
         volume_ff    <= volume_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = seq_idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   ksg_seq #(
      .PHASE_BITS (PHASE_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (req_tvalid & req_tready),
      .cmd          (req_tuser),
      .freq_hz      (req_tdata),
      .cfg          (cfg),
      .cfg_wr       (cfg_wr),
      .out_free     (out_free),
      .idle         (seq_idle),
      .result       (result),
      .mul_a        (mul_a),
      .mul_b        (mul_b),
      .mul_prod     (mul_prod),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   ksg_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   ksg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

`default_nettype wire

// ===== test/keyed_sidetone_generator_checker.sv =====
// ----------------------------------------------------------------------------
// keyed_sidetone_generator_checker: sample and tone-state scoreboard
// Watches the request, response and register channels of the sidetone block.
// It keeps its own copy of the tone state, ramp index, oscillator phase and
// registers. For each request transfer it computes the expected sample and
// tone state, then compares every response transfer with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyed_sidetone_generator_checker
   import ksg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data,
   output int               mismatch_count,
   output int               samples_pending
);

   localparam longint ONE_Q30 = 64'sd1073741824;

   typedef struct {
      logic [15:0] sample;
      tone_type    phase;
   } tick_result_t;

   tick_result_t expected_ticks[$];

   // Tone path state and register copies
   logic [4:0]  volume_reg;
   logic [11:0] attack_reg;
   logic [11:0] release_reg;
   tone_type    tone_now;
   logic [11:0] ramp_pos;
   logic [15:0] freq_now;
   logic [31:0] osc_acc;

   function automatic longint scale_q30(input longint a, input longint b);
      return (a * b) / ONE_Q30;
   endfunction

   // Quarter-wave sine polynomial, Q30 in and out
   function automatic longint quarter_sine(input longint x);
      longint x2;
      longint p;
      x2 = scale_q30(x, x);
      p = 64'sd172272;
      p = -64'sd5026996 + scale_q30(p, x2);
      p = 64'sd85569306 + scale_q30(p, x2);
      p = -64'sd693598669 + scale_q30(p, x2);
      p = 64'sd1686629713 + scale_q30(p, x2);
      p = scale_q30(p, x);
      if (p > ONE_Q30) p = ONE_Q30;
      if (p < 0) p = 0;
      return p;
   endfunction

   // Cosine of a 32-bit turn angle
   function automatic longint turn_cosine(input logic [31:0] t);
      logic [31:0] s;
      longint f;
      longint v;
      s = t + 32'h4000_0000;
      f = longint'(s[29:0]);
      if (s[30]) f = ONE_Q30 - f;
      v = quarter_sine(f);
      return s[31] ? -v : v;
   endfunction

   function automatic logic [11:0] odd_length(input logic [11:0] r);
      logic [12:0] n;
      n = (r == 12'd0) ? 13'd1 : {1'b0, r};
      if (!n[0]) n = n + 13'd1;
      if (n > 13'd4095) n = 13'd4095;
      return n[11:0];
   endfunction

   // Rising half of the Blackman-Harris window
   function automatic longint bh_rise(input logic [11:0] k, input logic [11:0] n);
      longint unsigned wide;
      logic [31:0] t;
      longint v;
      if (n <= 12'd1 || k >= n) return ONE_Q30;
      wide = (longint'(k) << 31) / longint'(n - 12'd1);
      t = wide[31:0];
      v = 64'sd385204879 - scale_q30(64'sd524297395, turn_cosine(t))
          + scale_q30(64'sd151698245, turn_cosine(t * 32'd2))
          - scale_q30(64'sd12541305, turn_cosine(t * 32'd3));
      if (v < 0) v = 0;
      if (v > ONE_Q30) v = ONE_Q30;
      return v;
   endfunction

   // Advance one sample tick and return the expected response
   function automatic tick_result_t next_tick(input logic [1:0] cmd,
                                              input logic [15:0] freq);
      tick_result_t r;
      longint env;
      longint v;
      longint s;
      longint gain;
      longint unsigned step;
      logic [11:0] n;
      logic [31:0] turn;
      env = ONE_Q30;
      if (cmd == CMD_ON) begin
         if (freq != freq_now) begin
            freq_now = freq;
            osc_acc  = '0;
         end
         tone_now = TONE_RISE;
         ramp_pos = '0;
      end else if (cmd == CMD_OFF && tone_now != TONE_OFF) begin
         tone_now = TONE_FALL;
         ramp_pos = '0;
      end
      if (tone_now == TONE_OFF) begin
         r.sample = '0;
         r.phase  = TONE_OFF;
         return r;
      end
      if (tone_now == TONE_RISE) begin
         n = odd_length(attack_reg);
         env = bh_rise(ramp_pos, n);
         if (ramp_pos < n) ramp_pos++;
         if (ramp_pos >= n) tone_now = TONE_ON;
      end else if (tone_now == TONE_FALL) begin
         n = odd_length(release_reg);
         env = ONE_Q30 - bh_rise(ramp_pos, n);
         if (ramp_pos < n) ramp_pos++;
         if (ramp_pos >= n) tone_now = TONE_OFF;
      end
      // 2^32 / 48000 = 89478 remainder 23296
      step = longint'(freq_now) * 89478 + (longint'(freq_now) * 23296) / 48000;
      osc_acc = osc_acc + step[31:0];
      turn = {osc_acc[31:22], 22'd0};
      v = scale_q30(env, turn_cosine(turn));
      gain = (volume_reg > 5'd20) ? 20 : longint'(volume_reg);
      s = (v * gain * 32768) / (20 * ONE_Q30);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      r.sample = s[15:0];
      r.phase  = tone_now;
      return r;
   endfunction

   assign samples_pending = expected_ticks.size();

   always @(posedge clock) begin
      tick_result_t want;
      if (reset) begin
         volume_reg     <= 5'd20;
         attack_reg     <= 12'd241;
         release_reg    <= 12'd241;
         tone_now       <= TONE_OFF;
         ramp_pos       <= '0;
         freq_now       <= '0;
         osc_acc        <= '0;
         mismatch_count <= 0;
         expected_ticks.delete();
      end else begin
         // Register write: a new ramp length restarts a running ramp
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_VOLUME: begin
                  volume_reg = csr_data[4:0];
               end
               REG_ATTACK: begin
                  attack_reg = csr_data;
                  if (tone_now == TONE_RISE) ramp_pos = '0;
               end
               REG_RELEASE: begin
                  release_reg = csr_data;
                  if (tone_now == TONE_FALL) ramp_pos = '0;
               end
               default: begin
               end
            endcase
         end
         // Compare the response transfer with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (expected_ticks.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response with none expected: sample %h phase %0d",
                           $realtime, rsp_tdata, rsp_tuser);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_tdata !== want.sample || rsp_tuser !== want.phase) begin
                  if (mismatch_count < 10)
                     $display("%0t: sample exp %h got %h, phase exp %0d got %0d",
                              $realtime, want.sample, rsp_tdata, want.phase, rsp_tuser);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         // Predict the request transfer
         if (req_tvalid && req_tready) begin
            expected_ticks.push_back(next_tick(req_tuser, req_tdata));
         end
      end
   end

endmodule

`default_nettype wire

// ===== test/keyed_sidetone_generator_tb.sv =====
// ----------------------------------------------------------------------------
// keyed_sidetone_generator_tb: stimulus and verdict for the sidetone block
// Runs key command sequences through several register settings (gain and
// ramp lengths at their extremes), with random gaps on both streams, one
// long response stall and idle pauses between settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyed_sidetone_generator_tb;
   import ksg_pkg::*;

   localparam int STALL_LIMIT = 40000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [11:0] csr_data;

   int          mismatch_count;
   int          samples_pending;
   int          ticks_sent;
   int          quiet_cycles;
   logic [15:0] last_freq;

   keyed_sidetone_generator uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   keyed_sidetone_generator_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .mismatch_count(mismatch_count), .samples_pending(samples_pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // No random gaps on either stream in this stretch
   function automatic logic no_gaps();
      return ticks_sent >= 800 && ticks_sent < 1000;
   endfunction

   // Send one tick, optionally after a short gap
   task automatic send_tick(input logic [1:0] cmd, input logic [15:0] freq);
      if (!no_gaps() && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= freq;
      if (cmd == CMD_ON) last_freq = freq;
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // Random tick: mostly none, with key on and off often enough to ramp
   task automatic send_random_tick();
      int r;
      logic [1:0] cmd;
      logic [15:0] freq;
      r = $urandom_range(0, 99);
      if (r < 8) cmd = CMD_ON;
      else if (r < 14) cmd = CMD_OFF;
      else if (r < 16) cmd = 2'd3;
      else cmd = CMD_NONE;
      freq = ($urandom_range(0, 2) == 0) ? last_freq : 16'($urandom_range(0, 65535));
      send_tick(cmd, freq);
   endtask

   // Drop valid and hold until every response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (samples_pending == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [11:0] vol, input logic [11:0] att,
                           input logic [11:0] rel);
      write_reg(REG_VOLUME, vol);
      write_reg(REG_ATTACK, att);
      write_reg(REG_RELEASE, rel);
   endtask

   // Response side: random stalls, one long hold-off
   initial begin
      bit held;
      held = 0;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && ticks_sent >= 500) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
         end
         rsp_tready <= no_gaps() || ($urandom_range(0, 99) >= 10);
      end
   end

   // Stop the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [11:0] vols[8] = '{12'd0, 12'd31, 12'd13, 12'd20, 12'd5, 12'd21, 12'd10, 12'd7};
      logic [11:0] atts[8] = '{12'd1, 12'd4095, 12'd0, 12'd17, 12'd40, 12'd7, 12'd3, 12'd2};
      logic [11:0] rels[8] = '{12'd1, 12'd4094, 12'd3, 12'd9, 12'd25, 12'd64, 12'd1, 12'd2048};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_NONE;
      csr_valid  <= 1'b0;
      csr_index  <= REG_VOLUME;
      csr_data   <= '0;
      ticks_sent = 0;
      last_freq  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset register values first
      repeat (120) send_random_tick();
      drain();

      // Directed: field extremes, same and new frequency, off while off
      set_regs(12'd20, 12'd5, 12'd3);
      send_tick(CMD_OFF, 16'hFFFF);
      send_tick(CMD_NONE, 16'h0000);
      send_tick(CMD_ON, 16'd0);
      send_tick(CMD_NONE, 16'd0);
      send_tick(CMD_ON, 16'd65535);
      repeat (3) send_tick(CMD_NONE, 16'h5555);
      send_tick(CMD_ON, 16'd65535);
      repeat (5) send_tick(2'd3, 16'hAAAA);
      send_tick(CMD_ON, 16'd24000);
      send_tick(CMD_ON, 16'd1000);
      repeat (5) send_tick(CMD_NONE, 16'd0);
      send_tick(CMD_OFF, 16'd0);
      repeat (4) send_tick(CMD_NONE, 16'd0);
      send_tick(CMD_OFF, 16'd0);
      drain();

      // Random phases over several register settings
      for (int p = 0; p < 8; p++) begin
         set_regs(vols[p], atts[p], rels[p]);
         repeat (140) send_random_tick();
         drain();
      end

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
